FILE: sv/vn2d_pkg.sv
`default_nettype none

package vn2d_pkg;

   // lattice size used unless the top level is told otherwise
   localparam int LATTICE_SIZE_DEFAULT = 64;

   // field widths
   localparam int COORD_W  = 32;
   localparam int FRAC_W   = 16;
   localparam int Q_W      = 17;
   localparam int IDX_W    = 12;
   localparam int CORNER_W = 8;

   // table geometry
   localparam int VAL_DEPTH  = 4096;
   localparam int VAL_AW     = 12;
   localparam int PERM_DEPTH = 128;
   localparam int PERM_AW    = 7;
   localparam int PERM_W     = 6;

   // 1.0 in unsigned Q1.16
   localparam logic [Q_W-1:0] ONE_Q16 = 17'd65536;

   // command codes carried in tuser
   typedef enum logic [1:0] {
      CMD_EVAL     = 2'd0,
      CMD_VALUE_WR = 2'd1,
      CMD_PERM_WR  = 2'd2
   } cmd_type;

   // control that travels down the pipeline with each transaction
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } stage_ctl_type;

endpackage

`default_nettype wire

FILE: sv/vn2d_ram.sv
`default_nettype none

module vn2d_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // one write port, two registered read ports, read returns old data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

FILE: sv/vn2d_wrap.sv
`default_nettype none

module vn2d_wrap #(
   parameter int LATTICE_SIZE = vn2d_pkg::LATTICE_SIZE_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           enable,
   input  wire logic [vn2d_pkg::COORD_W-1:0]   coord,
   output logic      [vn2d_pkg::CORNER_W-1:0]  lo,
   output logic      [vn2d_pkg::CORNER_W-1:0]  hi
);
   import vn2d_pkg::*;

   // bias makes the integer part non-negative without changing it mod the lattice
   localparam int INT_W       = COORD_W - FRAC_W;
   localparam int BIAS_MULT   = (32768 + LATTICE_SIZE - 1) / LATTICE_SIZE;
   localparam int BIAS        = BIAS_MULT * LATTICE_SIZE;
   localparam int U_W         = INT_W + 1;
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP       = (1 << RECIP_SHIFT) / LATTICE_SIZE;
   localparam int PROD_W      = U_W + RECIP_SHIFT;
   localparam int QL_W        = U_W + 9;
   localparam int R_W         = 10;

   logic signed [U_W:0]     biased;
   logic [U_W-1:0]          u_in;
   logic [U_W-1:0]          u_ff;
   logic [PROD_W-1:0]       prod_in;
   logic [PROD_W-1:0]       prod_ff;
   logic [U_W-1:0]          quot;
   logic [QL_W-1:0]         diff;
   logic [R_W-1:0]          rem;
   logic [R_W-1:0]          rem_fix;
   logic [CORNER_W-1:0]     lo_in;
   logic [CORNER_W-1:0]     hi_in;
   logic [CORNER_W-1:0]     lo_ff;
   logic [CORNER_W-1:0]     hi_ff;

   // stage one: floor, bias, reciprocal multiply
   always_comb begin
      biased  = $signed({{2{coord[COORD_W-1]}}, coord[COORD_W-1:FRAC_W]})
                + $signed((U_W+1)'(BIAS));
      u_in    = biased[U_W-1:0];
      prod_in = PROD_W'(u_in) * PROD_W'(RECIP);
   end

   // stage two: remainder with one correction step
   always_comb begin
      quot    = prod_ff[PROD_W-1:RECIP_SHIFT];
      diff    = QL_W'(u_ff) - QL_W'(quot) * QL_W'(LATTICE_SIZE);
      rem     = diff[R_W-1:0];
      rem_fix = (rem >= R_W'(LATTICE_SIZE)) ? rem - R_W'(LATTICE_SIZE) : rem;
      lo_in   = rem_fix[CORNER_W-1:0];
      hi_in   = (lo_in == CORNER_W'(LATTICE_SIZE - 1)) ? '0 : lo_in + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         u_ff    <= u_in;
         prod_ff <= prod_in;
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
      end
   end

   assign lo = lo_ff;
   assign hi = hi_ff;

endmodule

`default_nettype wire

FILE: sv/vn2d_ease.sv
`default_nettype none

module vn2d_ease (
   input  wire logic                        clock,
   input  wire logic                        enable,
   input  wire logic [vn2d_pkg::FRAC_W-1:0] frac,
   output logic      [vn2d_pkg::Q_W-1:0]    eased
);
   import vn2d_pkg::*;

   localparam int SQ_W  = 2 * FRAC_W;
   localparam int W_W   = FRAC_W + 2;
   localparam int P_W   = SQ_W + W_W;
   localparam int SHIFT = 2 * FRAC_W;

   logic [SQ_W-1:0] sq_ff;
   logic [W_W-1:0]  w_in;
   logic [W_W-1:0]  w_ff;
   logic [P_W-1:0]  p_ff;
   logic [P_W-1:0]  rnd;
   logic [Q_W-1:0]  s_ff;

   // s = t*t*(3 - 2t), rounded to Q1.16
   always_comb begin
      w_in = W_W'(3 * (1 << FRAC_W)) - {1'b0, frac, 1'b0};
      rnd  = p_ff + (P_W'(1) << (SHIFT - 1));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sq_ff <= SQ_W'(frac) * SQ_W'(frac);
         w_ff  <= w_in;
         p_ff  <= P_W'(sq_ff) * P_W'(w_ff);
         s_ff  <= rnd[SHIFT+Q_W-1:SHIFT];
      end
   end

   assign eased = s_ff;

endmodule

`default_nettype wire

FILE: sv/vn2d_blend.sv
`default_nettype none

module vn2d_blend (
   input  wire logic                     clock,
   input  wire logic                     enable,
   input  wire logic [vn2d_pkg::Q_W-1:0] c00,
   input  wire logic [vn2d_pkg::Q_W-1:0] c10,
   input  wire logic [vn2d_pkg::Q_W-1:0] c01,
   input  wire logic [vn2d_pkg::Q_W-1:0] c11,
   input  wire logic [vn2d_pkg::Q_W-1:0] sx,
   input  wire logic [vn2d_pkg::Q_W-1:0] sy,
   output logic      [vn2d_pkg::Q_W-1:0] result
);
   import vn2d_pkg::*;

   localparam int RP_W = 2 * Q_W;
   localparam int R_W  = 33;
   localparam int A_W  = R_W + Q_W;
   localparam int S_W  = A_W + 1;

   logic [Q_W-1:0]  sxn;
   logic [Q_W-1:0]  syn;
   logic [RP_W-1:0] r0_sum;
   logic [RP_W-1:0] r1_sum;
   logic [R_W-1:0]  r0_ff;
   logic [R_W-1:0]  r1_ff;
   logic [Q_W-1:0]  sy_ff;
   logic [A_W-1:0]  a0_ff;
   logic [A_W-1:0]  a1_ff;
   logic [S_W-1:0]  acc;

   // row blends in x, exact Q1.32
   always_comb begin
      sxn    = ONE_Q16 - sx;
      r0_sum = RP_W'(c00) * RP_W'(sxn) + RP_W'(c10) * RP_W'(sx);
      r1_sum = RP_W'(c01) * RP_W'(sxn) + RP_W'(c11) * RP_W'(sx);
      syn    = ONE_Q16 - sy_ff;
   end

   // column blend, single round at the end
   always_comb begin
      acc    = S_W'(a0_ff) + S_W'(a1_ff) + (S_W'(1) << 31);
      result = acc[32+Q_W-1:32];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         r0_ff <= r0_sum[R_W-1:0];
         r1_ff <= r1_sum[R_W-1:0];
         sy_ff <= sy;
         a0_ff <= A_W'(r0_ff) * A_W'(syn);
         a1_ff <= A_W'(r1_ff) * A_W'(sy_ff);
      end
   end

endmodule

`default_nettype wire

FILE: sv/value_noise_2d_smoothstep_unit.sv
// throughput: one transaction per cycle, set by the single-pass pipeline and dual-port tables,
// when the pipeline is not stalled by rsp_tready and no mirror write is pending
// a permutation write that mirrors into the upper half becomes two table writes
// reset: synchronous, clears valid bits and sets lookup_mode to hash indexing
// table contents are not cleared; user must have written them before reading (not enforced)
`default_nettype none

module value_noise_2d_smoothstep_unit #(
   parameter int LATTICE_SIZE = vn2d_pkg::LATTICE_SIZE_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // coord_x [31:0], coord_y [63:32], table_index [75:64], table_data [92:76]
   input  wire logic [95:0] req_tdata,
   // cmd [1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // noise_value [16:0]
   output logic [23:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_data
);
   import vn2d_pkg::*;

   localparam int NSTG = 7;
   localparam int ST_B = 0;
   localparam int ST_C = 1;
   localparam int ST_E = 3;
   localparam int ST_H = 6;

   logic                 en;
   logic                 a_load;
   logic                 req_acc;
   logic                 mirror;
   logic [IDX_W:0]       mirror_idx;
   logic                 perm_we;
   logic                 val_we;
   logic [Q_W-1:0]       val_sat;
   logic                 mode_ff;

   logic                 a_valid_ff;
   cmd_type              a_cmd_ff;
   logic [COORD_W-1:0]   a_x_ff;
   logic [COORD_W-1:0]   a_y_ff;
   logic [IDX_W-1:0]     a_idx_ff;
   logic [Q_W-1:0]       a_data_ff;
   logic                 split_ff;
   logic [IDX_W-1:0]     split_idx_ff;
   logic [PERM_W-1:0]    split_data_ff;

   stage_ctl_type        ctl_ff [NSTG];
   logic [IDX_W-1:0]     b_idx_ff, c_idx_ff, d_idx_ff, e_idx_ff;
   logic [Q_W-1:0]       b_data_ff, c_data_ff, d_data_ff, e_data_ff;

   logic [CORNER_W-1:0]  xl_c, xh_c, yl_c, yh_c;
   logic [CORNER_W-1:0]  d_yl_ff, d_yh_ff, d_xl_ff, d_xh_ff;
   logic [Q_W-1:0]       sx_d, sy_d;
   logic [Q_W-1:0]       e_sx_ff, e_sy_ff, f_sx_ff, f_sy_ff;

   logic [PERM_W-1:0]    h0_d, h1_d;
   logic [CORNER_W-1:0]  sum00, sum01, sum10, sum11;
   logic [PERM_W-1:0]    p00_e, p01_e, p10_e, p11_e;
   logic [19:0]          dir00, dir01, dir10, dir11;
   logic [VAL_AW-1:0]    e_dir00_ff, e_dir01_ff, e_dir10_ff, e_dir11_ff;
   logic [VAL_AW-1:0]    va00, va01, va10, va11;
   logic [Q_W-1:0]       c00_f, c01_f, c10_f, c11_f;

   logic [Q_W-1:0]       blend_res;
   logic                 rsp_valid_ff;
   logic [Q_W-1:0]       rsp_data_ff;

   // pipeline advances whenever the output register can take a result
   assign en         = !rsp_valid_ff || rsp_tready;
   assign a_load     = !a_valid_ff || en;
   assign req_tready = a_load && !split_ff;
   assign req_acc    = req_tvalid && req_tready;

   // permutation writes low in the table also land in the upper half
   assign mirror_idx = {1'b0, req_tdata[75:64]} + (IDX_W+1)'(LATTICE_SIZE);
   assign mirror     = (cmd_type'(req_tuser) == CMD_PERM_WR)
                       && (req_tdata[75:64] < IDX_W'(LATTICE_SIZE))
                       && (mirror_idx < (IDX_W+1)'(PERM_DEPTH));

   // configuration register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
      end else if (csr_valid) begin
         mode_ff <= csr_data;
      end
   end

   // input stage, with injection of the mirrored permutation write
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         split_ff   <= 1'b0;
      end else if (a_load) begin
         if (split_ff) begin
            a_valid_ff <= 1'b1;
            split_ff   <= 1'b0;
         end else begin
            a_valid_ff <= req_acc;
            split_ff   <= req_acc && mirror;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         if (split_ff) begin
            a_cmd_ff  <= CMD_PERM_WR;
            a_idx_ff  <= split_idx_ff;
            a_data_ff <= Q_W'(split_data_ff);
         end else begin
            a_cmd_ff  <= cmd_type'(req_tuser);
            a_x_ff    <= req_tdata[31:0];
            a_y_ff    <= req_tdata[63:32];
            a_idx_ff  <= req_tdata[75:64];
            a_data_ff <= req_tdata[92:76];
         end
      end
      if (req_acc) begin
         split_idx_ff  <= mirror_idx[IDX_W-1:0];
         split_data_ff <= req_tdata[76+PERM_W-1:76];
      end
   end

   // valid and command chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSTG; i++) begin
            ctl_ff[i].valid <= 1'b0;
            ctl_ff[i].cmd   <= CMD_EVAL;
         end
      end else if (en) begin
         ctl_ff[ST_B].valid <= a_valid_ff;
         ctl_ff[ST_B].cmd   <= a_cmd_ff;
         for (int i = 1; i < NSTG; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   // floor and wrap of the lattice corners
   vn2d_wrap #(.LATTICE_SIZE(LATTICE_SIZE)) u_wrap_x (
      .clock(clock), .enable(en), .coord(a_x_ff), .lo(xl_c), .hi(xh_c)
   );
   vn2d_wrap #(.LATTICE_SIZE(LATTICE_SIZE)) u_wrap_y (
      .clock(clock), .enable(en), .coord(a_y_ff), .lo(yl_c), .hi(yh_c)
   );

   // smoothstep of both fractions
   vn2d_ease u_ease_x (
      .clock(clock), .enable(en), .frac(a_x_ff[FRAC_W-1:0]), .eased(sx_d)
   );
   vn2d_ease u_ease_y (
      .clock(clock), .enable(en), .frac(a_y_ff[FRAC_W-1:0]), .eased(sy_d)
   );

   // payload carried alongside the arithmetic
   always_ff @(posedge clock) begin
      if (en) begin
         b_idx_ff   <= a_idx_ff;
         b_data_ff  <= a_data_ff;
         c_idx_ff   <= b_idx_ff;
         c_data_ff  <= b_data_ff;
         d_idx_ff   <= c_idx_ff;
         d_data_ff  <= c_data_ff;
         e_idx_ff   <= d_idx_ff;
         e_data_ff  <= d_data_ff;
         d_xl_ff    <= xl_c;
         d_xh_ff    <= xh_c;
         d_yl_ff    <= yl_c;
         d_yh_ff    <= yh_c;
         e_sx_ff    <= sx_d;
         e_sy_ff    <= sy_d;
         f_sx_ff    <= e_sx_ff;
         f_sy_ff    <= e_sy_ff;
         e_dir00_ff <= dir00[VAL_AW-1:0];
         e_dir01_ff <= dir01[VAL_AW-1:0];
         e_dir10_ff <= dir10[VAL_AW-1:0];
         e_dir11_ff <= dir11[VAL_AW-1:0];
      end
   end

   // permutation table writes line up with the first hash read
   assign perm_we = en && ctl_ff[ST_C].valid && (ctl_ff[ST_C].cmd == CMD_PERM_WR)
                    && (c_idx_ff[IDX_W-1:PERM_AW] == '0);

   vn2d_ram #(.WIDTH(PERM_W), .DEPTH(PERM_DEPTH)) u_perm_l1 (
      .clock(clock), .wr_en(perm_we), .wr_addr(c_idx_ff[PERM_AW-1:0]),
      .wr_data(c_data_ff[PERM_W-1:0]), .rd_en(en),
      .rd_addr_a(xl_c[PERM_AW-1:0]), .rd_addr_b(xh_c[PERM_AW-1:0]),
      .rd_data_a(h0_d), .rd_data_b(h1_d)
   );

   // second hash level and direct grid addresses
   always_comb begin
      sum00 = {2'b00, h0_d} + d_yl_ff;
      sum01 = {2'b00, h0_d} + d_yh_ff;
      sum10 = {2'b00, h1_d} + d_yl_ff;
      sum11 = {2'b00, h1_d} + d_yh_ff;
      dir00 = 20'(d_yl_ff) * 20'(LATTICE_SIZE) + 20'(d_xl_ff);
      dir01 = 20'(d_yh_ff) * 20'(LATTICE_SIZE) + 20'(d_xl_ff);
      dir10 = 20'(d_yl_ff) * 20'(LATTICE_SIZE) + 20'(d_xh_ff);
      dir11 = 20'(d_yh_ff) * 20'(LATTICE_SIZE) + 20'(d_xh_ff);
   end

   vn2d_ram #(.WIDTH(PERM_W), .DEPTH(PERM_DEPTH)) u_perm_l2a (
      .clock(clock), .wr_en(perm_we), .wr_addr(c_idx_ff[PERM_AW-1:0]),
      .wr_data(c_data_ff[PERM_W-1:0]), .rd_en(en),
      .rd_addr_a(sum00[PERM_AW-1:0]), .rd_addr_b(sum01[PERM_AW-1:0]),
      .rd_data_a(p00_e), .rd_data_b(p01_e)
   );
   vn2d_ram #(.WIDTH(PERM_W), .DEPTH(PERM_DEPTH)) u_perm_l2b (
      .clock(clock), .wr_en(perm_we), .wr_addr(c_idx_ff[PERM_AW-1:0]),
      .wr_data(c_data_ff[PERM_W-1:0]), .rd_en(en),
      .rd_addr_a(sum10[PERM_AW-1:0]), .rd_addr_b(sum11[PERM_AW-1:0]),
      .rd_data_a(p10_e), .rd_data_b(p11_e)
   );

   // value table reads, writes line up with the read stage
   always_comb begin
      val_sat = (e_data_ff > ONE_Q16) ? ONE_Q16 : e_data_ff;
      val_we  = en && ctl_ff[ST_E].valid && (ctl_ff[ST_E].cmd == CMD_VALUE_WR);
      va00    = mode_ff ? VAL_AW'(p00_e) : e_dir00_ff;
      va01    = mode_ff ? VAL_AW'(p01_e) : e_dir01_ff;
      va10    = mode_ff ? VAL_AW'(p10_e) : e_dir10_ff;
      va11    = mode_ff ? VAL_AW'(p11_e) : e_dir11_ff;
   end

   vn2d_ram #(.WIDTH(Q_W), .DEPTH(VAL_DEPTH)) u_val_a (
      .clock(clock), .wr_en(val_we), .wr_addr(e_idx_ff), .wr_data(val_sat),
      .rd_en(en), .rd_addr_a(va00), .rd_addr_b(va01),
      .rd_data_a(c00_f), .rd_data_b(c01_f)
   );
   vn2d_ram #(.WIDTH(Q_W), .DEPTH(VAL_DEPTH)) u_val_b (
      .clock(clock), .wr_en(val_we), .wr_addr(e_idx_ff), .wr_data(val_sat),
      .rd_en(en), .rd_addr_a(va10), .rd_addr_b(va11),
      .rd_data_a(c10_f), .rd_data_b(c11_f)
   );

   // bilinear blend
   vn2d_blend u_blend (
      .clock(clock), .enable(en),
      .c00(c00_f), .c10(c10_f), .c01(c01_f), .c11(c11_f),
      .sx(f_sx_ff), .sy(f_sy_ff), .result(blend_res)
   );

   // output register, only evaluate transactions give a result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= ctl_ff[ST_H].valid && (ctl_ff[ST_H].cmd == CMD_EVAL);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= blend_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff};

   // a pending mirror write blocks new requests
   assert property (@(posedge clock) disable iff (reset) split_ff |-> !req_tready)
      else $error("request taken while mirror write pending");

   // an evaluate at the last stage becomes a result when the pipe moves
   assert property (@(posedge clock) disable iff (reset)
      en && ctl_ff[ST_H].valid && (ctl_ff[ST_H].cmd == CMD_EVAL) |=> rsp_tvalid)
      else $error("evaluate result lost");

   // no table write while the pipeline is stalled
   assert property (@(posedge clock) disable iff (reset) !en |-> !perm_we && !val_we)
      else $error("table written during stall");

   // write commands never produce a result
   assert property (@(posedge clock) disable iff (reset)
      en && ctl_ff[ST_H].valid && (ctl_ff[ST_H].cmd != CMD_EVAL) |=> !rsp_tvalid)
      else $error("result from a write command");

endmodule

`default_nettype wire
